>>> rtl/core/gsp_pkg.sv
package gsp_pkg;
    typedef enum logic [1:0] {
        OP_SPAWN = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_MARK = 2'd2,
        OP_SWEEP = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [15:0] gen;
    } t_cmd;
endpackage

>>> rtl/core/gsp_ram.sv
module gsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/gsp_front.sv
module gsp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_operation,
    input  logic [7:0]    i_handle_index,
    input  logic [15:0]   i_handle_generation,
    output logic          o_q_valid,
    input  logic          i_q_ready,
    output gsp_pkg::t_cmd o_q_cmd
);
    import gsp_pkg::*;

    // two-entry queue between intake and execution
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop = o_q_valid && i_q_ready;
    assign o_q_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: i_operation, idx: i_handle_index, gen: i_handle_generation};
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> rtl/core/gsp_back.sv
module gsp_back #(
    parameter int SLOTS = 64,
    parameter int GEN_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  gsp_pkg::t_cmd i_q_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_status,
    output logic [5:0]    o_slot_idx,
    output logic [15:0]   o_slot_generation_out,
    output logic [6:0]    o_freed_count,
    output logic [6:0]    o_active_total,
    output logic [6:0]    o_free_total
);
    import gsp_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_SP_RD, S_EXEC, S_SW_RD, S_SW_WAIT, S_SW_CHK, S_DONE
    } t_state;

    t_state r_state;
    t_cmd r_cmd;
    logic [CW-1:0] r_free_top, r_act_top, r_cur, r_freed;
    logic [SLOTS-1:0] r_in_use, r_alive, r_fs_valid;
    logic [IW-1:0] r_slot;

    logic fs_we, al_we, g_we;
    logic [IW-1:0] fs_wa, fs_ra, fs_wd, fs_rd, al_wa, al_wd, al_ra, al_rd, g_wa, g_ra;
    logic [GEN_BITS-1:0] g_wd, g_rd, g_next;
    logic [IW-1:0] fs_val, hidx;
    logic hbad;

    gsp_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_fs (
        .i_clk, .i_we(fs_we), .i_waddr(fs_wa), .i_wdata(fs_wd),
        .i_raddr(fs_ra), .o_rdata(fs_rd));
    gsp_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_al (
        .i_clk, .i_we(al_we), .i_waddr(al_wa), .i_wdata(al_wd),
        .i_raddr(al_ra), .o_rdata(al_rd));
    gsp_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOTS)) u_gen (
        .i_clk, .i_we(g_we), .i_waddr(g_wa), .i_wdata(g_wd),
        .i_raddr(g_ra), .o_rdata(g_rd));

    // generation store valid bits double as zero reset via in-use history
    logic [SLOTS-1:0] r_gen_valid;
    logic [GEN_BITS-1:0] gen_cur;

    assign hbad = ({24'd0, r_cmd.idx} >= 32'(SLOTS));
    assign hidx = r_cmd.idx[IW-1:0];
    assign fs_val = r_fs_valid[fs_ra] ? fs_rd : IW'(SLOTS - 1 - int'(fs_ra));
    assign o_q_ready = (r_state == S_IDLE);

    logic [IW-1:0] r_fs_ra_q;
    assign fs_ra = r_fs_ra_q;
    logic [IW-1:0] r_g_ra;
    // spawn reads the generation of the slot it is about to pop
    assign g_ra = (r_state == S_SP_RD) ? fs_val : r_g_ra;
    assign gen_cur = r_gen_valid[r_g_ra] ? g_rd : '0;
    assign g_next = (gen_cur + 1'b1 == '0) ? GEN_BITS'(1) : gen_cur + 1'b1;
    assign al_ra = (r_state == S_SW_CHK || r_state == S_SW_WAIT) ?
        r_act_top[IW-1:0] - IW'(1) : r_cur[IW-1:0];

    logic [IW-1:0] spawn_s;
    assign spawn_s = fs_val;

    always_comb begin
        fs_we = 1'b0; fs_wa = r_free_top[IW-1:0]; fs_wd = r_slot;
        al_we = 1'b0; al_wa = r_act_top[IW-1:0]; al_wd = spawn_s;
        g_we = 1'b0; g_wa = r_g_ra; g_wd = g_next;
        if (r_state == S_EXEC && r_cmd.op == OP_SPAWN &&
            r_free_top != '0 && r_act_top < SLOTS_C) begin
            al_we = 1'b1;
            g_we = 1'b1;
        end
        if (r_state == S_SW_CHK && !(r_in_use[r_slot] && r_alive[r_slot])) begin
            fs_we = (r_free_top < SLOTS_C);
            al_we = 1'b1;
            al_wa = r_cur[IW-1:0];
            al_wd = al_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free_top <= SLOTS_C;
            r_act_top <= '0;
            r_in_use <= '0;
            r_alive <= '0;
            r_fs_valid <= '0;
            r_gen_valid <= '0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_cmd;
                        r_state <= (i_q_cmd.op == OP_SWEEP) ? S_SW_RD : S_RD;
                        r_fs_ra_q <= r_free_top[IW-1:0] - IW'(1);
                        r_g_ra <= i_q_cmd.idx[IW-1:0];
                        r_cur <= '0;
                        r_freed <= '0;
                    end
                end
                S_RD: begin
                    r_state <= (r_cmd.op == OP_SPAWN) ? S_SP_RD : S_EXEC;
                end
                S_SP_RD: begin
                    // popped slot is known now, its generation arrives next cycle
                    r_g_ra <= fs_val;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    o_slot_idx <= '0;
                    o_slot_generation_out <= '0;
                    o_freed_count <= '0;
                    if (r_cmd.op == OP_SPAWN) begin
                        if (r_free_top == '0 || r_act_top >= SLOTS_C) begin
                            o_status <= ST_FULL;
                        end else begin
                            o_status <= ST_OK;
                            r_in_use[spawn_s] <= 1'b1;
                            r_alive[spawn_s] <= 1'b1;
                            r_gen_valid[spawn_s] <= 1'b1;
                            r_free_top <= r_free_top - 1'b1;
                            r_act_top <= r_act_top + 1'b1;
                            o_slot_idx <= 6'(spawn_s);
                            o_slot_generation_out <= 16'(g_next);
                        end
                    end else if (hbad) begin
                        o_status <= ST_FULL;
                    end else if (!r_in_use[hidx] ||
                                 32'(gen_cur) != {16'd0, r_cmd.gen}) begin
                        o_status <= ST_STALE;
                    end else begin
                        o_status <= ST_OK;
                        if (r_cmd.op == OP_MARK) r_alive[hidx] <= 1'b0;
                        o_slot_idx <= 6'(hidx);
                        o_slot_generation_out <= 16'(gen_cur);
                    end
                    r_state <= S_DONE;
                end
                S_SW_RD: begin
                    if (r_cur >= r_act_top) begin
                        o_status <= ST_OK;
                        o_slot_idx <= '0;
                        o_slot_generation_out <= '0;
                        o_freed_count <= 7'(r_freed);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SW_WAIT;
                    end
                end
                S_SW_WAIT: begin
                    r_slot <= al_rd;
                    r_state <= S_SW_CHK;
                end
                S_SW_CHK: begin
                    // al_rd now holds the last list entry
                    if (r_in_use[r_slot] && r_alive[r_slot]) begin
                        r_cur <= r_cur + 1'b1;
                    end else begin
                        r_in_use[r_slot] <= 1'b0;
                        if (r_free_top < SLOTS_C) begin
                            r_fs_valid[r_free_top[IW-1:0]] <= 1'b1;
                            r_free_top <= r_free_top + 1'b1;
                        end
                        r_freed <= r_freed + 1'b1;
                        r_act_top <= r_act_top - 1'b1;
                    end
                    r_state <= S_SW_RD;
                end
                S_DONE: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_active_total <= 7'(r_act_top);
                        o_free_total <= 7'(r_free_top);
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/generational_slot_pool_top.sv
// generational slot pool
// lookup, mark_dead: the beat passes the queue, then S_IDLE, S_RD, S_EXEC and S_DONE, which
// registers o_valid; spawn adds S_SP_RD (extra generation read); sweep walks the active list
// with registered reads, S_SW_RD, S_SW_WAIT, S_SW_CHK per entry; the back end takes the next
// queued item in the cycle after the result beat, none before; a two-beat queue buffers input
// i_rst_n synchronous active low: free stack full, no active slots, all generations zero
module generational_slot_pool_top #(
    parameter int SLOTS = 64,
    parameter int GEN_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_handle_index,
    input  logic [15:0] i_handle_generation,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot_idx,
    output logic [15:0] o_slot_generation_out,
    output logic [6:0]  o_freed_count,
    output logic [6:0]  o_active_total,
    output logic [6:0]  o_free_total
);
    import gsp_pkg::*;

    logic q_valid, q_ready;
    t_cmd q_cmd;

    gsp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation, .i_handle_index,
        .i_handle_generation, .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_cmd(q_cmd));

    gsp_back #(.SLOTS(SLOTS), .GEN_BITS(GEN_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_cmd(q_cmd),
        .o_valid, .i_ready, .o_status, .o_slot_idx, .o_slot_generation_out,
        .o_freed_count, .o_active_total, .o_free_total);
endmodule

>>> tb/sv/gsp_checker.sv
`timescale 1ns / 100ps
module gsp_checker #(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_handle_index,
    input  logic [15:0] i_handle_generation,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [5:0]  i_slot_idx,
    input  logic [15:0] i_slot_generation_out,
    input  logic [6:0]  i_freed_count,
    input  logic [6:0]  i_active_total,
    input  logic [6:0]  i_free_total,
    output int          o_fail_count,
    output int          o_pending
);
    import gsp_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  idx;
        logic [15:0] gen;
        logic [6:0]  freed;
        logic [6:0]  act;
        logic [6:0]  fre;
    } t_pool_result;

    logic [5:0]  free_stack [SLOTS];
    int          free_top;
    logic [5:0]  active_list [SLOTS];
    int          active_top;
    logic        in_use [SLOTS];
    logic        alive [SLOTS];
    logic [15:0] gen_tag [SLOTS];
    t_pool_result expected_results [$];

    function automatic t_pool_result pool_apply(logic [1:0] op, logic [7:0] idx,
                                                logic [15:0] gen);
        t_pool_result r;
        int s, cur, freed;
        logic [15:0] g;
        r = '0;
        if (op == OP_SPAWN) begin
            if (free_top == 0 || active_top >= SLOTS) begin
                r.status = ST_FULL;
            end else begin
                free_top--;
                s = free_stack[free_top];
                in_use[s] = 1'b1;
                alive[s] = 1'b1;
                g = gen_tag[s] + 16'd1;
                if (g == 16'd0) g = 16'd1;
                gen_tag[s] = g;
                active_list[active_top] = s[5:0];
                active_top++;
                r.status = ST_OK;
                r.idx = s[5:0];
                r.gen = g;
            end
        end else if (op == OP_LOOKUP || op == OP_MARK) begin
            if (idx >= SLOTS) begin
                r.status = ST_FULL;
            end else if (!in_use[idx] || gen_tag[idx] != gen) begin
                r.status = ST_STALE;
            end else begin
                if (op == OP_MARK) alive[idx] = 1'b0;
                r.status = ST_OK;
                r.idx = idx[5:0];
                r.gen = gen_tag[idx];
            end
        end else begin
            cur = 0;
            freed = 0;
            while (cur < active_top) begin
                s = active_list[cur];
                if (in_use[s] && alive[s]) begin
                    cur++;
                end else begin
                    in_use[s] = 1'b0;
                    if (free_top < SLOTS) begin
                        free_stack[free_top] = s[5:0];
                        free_top++;
                    end
                    freed++;
                    active_top--;
                    active_list[cur] = active_list[active_top];
                end
            end
            r.status = ST_OK;
            r.freed = freed[6:0];
        end
        r.act = active_top[6:0];
        r.fre = free_top[6:0];
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_pool_result e;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                free_stack[i] = 6'(SLOTS - 1 - i);
                active_list[i] = '0;
                in_use[i] = 1'b0;
                alive[i] = 1'b0;
                gen_tag[i] = '0;
            end
            free_top = SLOTS;
            active_top = 0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_valid && i_in_ready)
                expected_results.push_back(pool_apply(i_operation, i_handle_index,
                                                      i_handle_generation));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.status !== i_status) begin
                        $error("status exp %0d got %0d", e.status, i_status);
                        o_fail_count++;
                    end
                    if (e.idx !== i_slot_idx) begin
                        $error("slot_idx exp %0d got %0d", e.idx, i_slot_idx);
                        o_fail_count++;
                    end
                    if (e.gen !== i_slot_generation_out) begin
                        $error("slot_generation_out exp %0d got %0d", e.gen,
                               i_slot_generation_out);
                        o_fail_count++;
                    end
                    if (e.freed !== i_freed_count) begin
                        $error("freed_count exp %0d got %0d", e.freed, i_freed_count);
                        o_fail_count++;
                    end
                    if (e.act !== i_active_total) begin
                        $error("active_total exp %0d got %0d", e.act, i_active_total);
                        o_fail_count++;
                    end
                    if (e.fre !== i_free_total) begin
                        $error("free_total exp %0d got %0d", e.fre, i_free_total);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
    import gsp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = '0;
    logic [7:0]  hidx = '0;
    logic [15:0] hgen = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [5:0]  slot_idx;
    logic [15:0] slot_gen;
    logic [6:0]  freed_count, active_total, free_total;
    int          fail_count, pending;
    int          cycle_count = 0;
    logic        stim_done = 1'b0;
    logic        long_stall = 1'b0;

    // recent spawned handles, reused for well-formed lookups and marks
    logic [5:0]  live_idx [$];
    logic [15:0] live_gen [$];

    always #4 clk = ~clk;

    generational_slot_pool_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_operation(op), .i_handle_index(hidx), .i_handle_generation(hgen),
        .o_valid(out_valid), .i_ready(out_ready), .o_status(status),
        .o_slot_idx(slot_idx), .o_slot_generation_out(slot_gen),
        .o_freed_count(freed_count), .o_active_total(active_total),
        .o_free_total(free_total)
    );

    gsp_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_operation(op), .i_handle_index(hidx), .i_handle_generation(hgen),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_status(status),
        .i_slot_idx(slot_idx), .i_slot_generation_out(slot_gen),
        .i_freed_count(freed_count), .i_active_total(active_total),
        .i_free_total(free_total), .o_fail_count(fail_count), .o_pending(pending)
    );

    // capture handles of ok results with a nonzero generation (spawns, lookups and marks)
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready && status == ST_OK && slot_gen != 0
            && freed_count == 0) begin
            live_idx.push_back(slot_idx);
            live_gen.push_back(slot_gen);
            if (live_idx.size() > 32) begin
                void'(live_idx.pop_front());
                void'(live_gen.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern plus one long hold-off
    initial begin
        int n;
        @(posedge clk iff rst_n);
        repeat (300) @(posedge clk);
        long_stall = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_stall = 1'b0;
        forever begin
            n = $urandom_range(1, 30);
            case ($urandom_range(0, 2))
                0: repeat (n) begin out_ready <= 1'b1; @(posedge clk); end
                1: repeat (n) begin out_ready <= ($urandom_range(0, 3) != 0); @(posedge clk); end
                default: repeat ($urandom_range(1, 6)) begin out_ready <= 1'b0; @(posedge clk); end
            endcase
        end
    end

    task automatic send_beat(logic [1:0] o, logic [7:0] i, logic [15:0] g);
        op <= o;
        hidx <= i;
        hgen <= g;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic pick_random;
        int k, sel;
        k = $urandom_range(0, 99);
        sel = live_idx.size() ? $urandom_range(0, live_idx.size() - 1) : 0;
        if (k < 35) send_beat(OP_SPAWN, 8'($urandom), 16'($urandom));
        else if (k < 60 && live_idx.size())
            send_beat(OP_LOOKUP, {2'b00, live_idx[sel]}, live_gen[sel]);
        else if (k < 80 && live_idx.size())
            send_beat(OP_MARK, {2'b00, live_idx[sel]}, live_gen[sel]);
        else if (k < 88) send_beat(OP_SWEEP, 8'($urandom), 16'($urandom));
        else send_beat(t_op'($urandom_range(1, 2)), 8'($urandom),
                       ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 3)));
    endtask

    initial begin
        int sent;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty sweep, stale handles, out of range, spawn, mark, repeat mark
        send_beat(OP_SWEEP, 8'hff, 16'hffff);
        send_beat(OP_LOOKUP, 8'd0, 16'd0);
        send_beat(OP_LOOKUP, 8'd255, 16'hffff);
        send_beat(OP_MARK, 8'd64, 16'd1);
        send_beat(OP_SPAWN, 8'd0, 16'd0);
        send_beat(OP_LOOKUP, 8'd0, 16'd1);
        send_beat(OP_LOOKUP, 8'd0, 16'd2);
        send_beat(OP_MARK, 8'd0, 16'd1);
        send_beat(OP_MARK, 8'd0, 16'd1);
        send_beat(OP_LOOKUP, 8'd0, 16'd1);
        send_beat(OP_SWEEP, 8'd0, 16'd0);
        send_beat(OP_LOOKUP, 8'd0, 16'd1);
        send_beat(OP_SPAWN, 8'hff, 16'hffff);
        send_beat(OP_LOOKUP, 8'd63, 16'hffff);
        sent = 0;
        while (sent < 650) begin
            // bursts; occasionally fill the pool to reach the full case
            if ($urandom_range(0, 19) == 0) begin
                repeat (66) send_beat(OP_SPAWN, 8'($urandom), 16'($urandom));
                sent += 66;
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    pick_random();
                    sent++;
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
